// ----- hdl/ghdb_pkg.sv -----
// ----------------------------------------------------------------------------
// ghdb_pkg
// Shared constants, types and helpers for the haversine distance band block.
// ----------------------------------------------------------------------------
package ghdb_pkg;

  localparam int unsigned CordicIterations = 24;
  localparam int unsigned NumIter = (CordicIterations > 32) ? 32 : CordicIterations;
  localparam int unsigned DivSteps = 66;

  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  localparam logic signed [32:0] DegQuarter = 33'sd754974720;
  localparam logic signed [32:0] DegHalf = 33'sd1509949440;
  localparam logic signed [33:0] DegTurn = 34'sd3019898880;
  localparam logic [26:0] Deg2RadQ32 = 27'd74961321;
  localparam logic signed [33:0] CordicKQ30 = 34'sd652032875;
  localparam logic signed [29:0] LatLimit = 30'sd377487360;
  localparam logic signed [30:0] LonLimit = 31'sd754974720;
  localparam logic [22:0] RadiusMin = 23'd6356800;
  localparam logic [22:0] RadiusMax = 23'd6378100;
  localparam logic [22:0] RadiusReset = 23'd6371000;
  localparam logic [30:0] DistMax = 31'd2004000000;

  localparam logic [1:0] StatusNoFix = 2'd0;
  localparam logic [1:0] StatusNoTarget = 2'd1;
  localparam logic [1:0] StatusValid = 2'd2;
  localparam logic [2:0] BandFar = 3'd5;

  localparam logic [1:0] RegLat = 2'd0;
  localparam logic [1:0] RegLon = 2'd1;
  localparam logic [1:0] RegRad = 2'd2;
  localparam logic [1:0] RegEn = 2'd3;

  function automatic logic signed [33:0] atan_q30(input int unsigned i);
    logic signed [33:0] t [32];
    t = '{34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
          34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
          34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288, 34'sd262144,
          34'sd131072, 34'sd65536, 34'sd32768, 34'sd16384, 34'sd8192,
          34'sd4096, 34'sd2048, 34'sd1024, 34'sd512, 34'sd256, 34'sd128,
          34'sd64, 34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2, 34'sd1, 34'sd0};
    return t[i[4:0]];
  endfunction

  typedef struct packed {
    logic [1:0]  status;
    logic [22:0] radius;
  } side_t;

endpackage

// ----- hdl/ghdb_sincos.sv -----
// ----------------------------------------------------------------------------
// ghdb_sincos
// Pipelined rotation CORDIC: Q23 degree angle to Q30 sin and cos, one stage
// per iteration plus reduction, radian conversion, correction and sign stages.
// ----------------------------------------------------------------------------
module ghdb_sincos (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] ang_i,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);
  import ghdb_pkg::*;

  logic signed [33:0] r_d, m_d;
  logic sneg_d, cneg_d;
  logic [59:0] zp;
  logic signed [33:0] z_q [NumIter+1];
  logic signed [33:0] x_q [NumIter+1];
  logic signed [33:0] y_q [NumIter+1];
  logic sn_q [NumIter+1];
  logic cn_q [NumIter+1];
  logic signed [33:0] m_q;
  logic sneg_q, cneg_q;

  // input magnitude stays below one turn, so one fold per side suffices
  always_comb begin
    r_d = ang_i;
    if (r_d >= 34'(DegHalf)) r_d = r_d - DegTurn;
    if (r_d < -34'(DegHalf)) r_d = r_d + DegTurn;
    sneg_d = r_d < 0;
    m_d = sneg_d ? -r_d : r_d;
    cneg_d = 1'b0;
    if (m_d > 34'(DegQuarter)) begin
      m_d = 34'(DegHalf) - m_d;
      cneg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
      sneg_q <= sneg_d;
      cneg_q <= cneg_d;
    end
  end

  assign zp = (60'(m_q) * 60'(Deg2RadQ32) + (60'd1 << 24)) >> 25;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= 34'(zp);
      x_q[0] <= CordicKQ30;
      y_q[0] <= '0;
      sn_q[0] <= sneg_q;
      cn_q[0] <= cneg_q;
    end
  end

  for (genvar i = 0; i < NumIter; i++) begin : g_it
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_q30(i);
        end
        sn_q[i+1] <= sn_q[i];
        cn_q[i+1] <= cn_q[i];
      end
    end
  end

  // residual correction: products are small (z residue is tiny)
  logic signed [67:0] zy_q, zx_q;
  logic signed [33:0] xc_q, yc_q;
  logic sf_q, cf_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zy_q <= 68'(z_q[NumIter]) * 68'(y_q[NumIter]);
      zx_q <= 68'(z_q[NumIter]) * 68'(x_q[NumIter]);
      xc_q <= x_q[NumIter];
      yc_q <= y_q[NumIter];
      sf_q <= sn_q[NumIter];
      cf_q <= cn_q[NumIter];
    end
  end

  logic signed [35:0] xr, yr, xl, yl;
  always_comb begin
    xr = 36'(xc_q) - 36'(zy_q >>> 30);
    yr = 36'(yc_q) + 36'(zx_q >>> 30);
    xl = (xr > 36'(OneQ30)) ? 36'(OneQ30) : ((xr < -36'(OneQ30)) ? -36'(OneQ30) : xr);
    yl = (yr > 36'(OneQ30)) ? 36'(OneQ30) : ((yr < -36'(OneQ30)) ? -36'(OneQ30) : yr);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sf_q ? -34'(yl) : 34'(yl);
      cos_o <= cf_q ? -34'(xl) : 34'(xl);
    end
  end
endmodule

// ----- hdl/ghdb_isqrt.sv -----
// ----------------------------------------------------------------------------
// ghdb_isqrt
// Pipelined floor square root of a 62-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module ghdb_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [61:0] v_i,
  output logic [30:0] r_o
);
  import ghdb_pkg::*;

  localparam int unsigned Steps = 31;
  logic [62:0] v_q [Steps+1];
  logic [62:0] r_q [Steps+1];

  always_comb begin
    v_q[0] = 63'(v_i);
    r_q[0] = '0;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_st
    localparam logic [62:0] B = 63'd1 << (2 * (Steps - 1 - i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_q[i] >= r_q[i] + B) begin
          v_q[i+1] <= v_q[i] - (r_q[i] + B);
          r_q[i+1] <= (r_q[i] >> 1) + B;
        end else begin
          v_q[i+1] <= v_q[i];
          r_q[i+1] <= r_q[i] >> 1;
        end
      end
    end
  end

  assign r_o = r_q[Steps][30:0];
endmodule

// ----- hdl/ghdb_asin.sv -----
// ----------------------------------------------------------------------------
// ghdb_asin
// Pipelined asin of a Q30 value: sqrt(1-q^2), vectoring CORDIC, then a
// residual step y/x done bit by bit.
// ----------------------------------------------------------------------------
module ghdb_asin (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] q_i,
  output logic [31:0]        ang_o
);
  import ghdb_pkg::*;

  localparam int unsigned Lat = 31;
  logic [61:0] rem;
  logic [30:0] xs;
  logic signed [33:0] qd_q [Lat+1];

  assign rem = 62'((64'sd1 << 60) - 64'(q_i) * 64'(q_i));

  ghdb_isqrt u_sq (.clk_i, .en_i, .v_i(rem), .r_o(xs));

  assign qd_q[0] = q_i;
  for (genvar i = 0; i < Lat; i++) begin : g_d
    always_ff @(posedge clk_i) if (en_i) qd_q[i+1] <= qd_q[i];
  end

  logic signed [35:0] x_q [NumIter+1];
  logic signed [35:0] y_q [NumIter+1];
  logic signed [35:0] z_q [NumIter+1];
  always_comb begin
    x_q[0] = 36'(xs);
    y_q[0] = 36'(qd_q[Lat]);
    z_q[0] = '0;
  end

  for (genvar i = 0; i < NumIter; i++) begin : g_it
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + 36'(atan_q30(i));
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - 36'(atan_q30(i));
        end
      end
    end
  end

  // truncating divide (|y| << 30) / x, restoring, one quotient bit per stage
  localparam int unsigned QB = DivSteps;
  logic [65:0] n_q [QB+1];
  logic [36:0] p_q [QB+1];
  logic [65:0] qo_q [QB+1];
  logic [35:0] d_q [QB+1];
  logic ng_q [QB+1];
  logic ok_q [QB+1];
  logic signed [35:0] zz_q [QB+1];
  logic signed [35:0] yf, xf;
  assign yf = y_q[NumIter];
  assign xf = x_q[NumIter];
  always_comb begin
    n_q[0] = {36'(yf < 0 ? -yf : yf), 30'd0};
    p_q[0] = '0;
    qo_q[0] = '0;
    d_q[0] = xf[35:0];
    ng_q[0] = yf < 0;
    ok_q[0] = xf > 0;
    zz_q[0] = z_q[NumIter];
  end

  for (genvar i = 0; i < QB; i++) begin : g_dv
    logic [36:0] pt;
    assign pt = {p_q[i][35:0], n_q[i][65]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1] <= n_q[i] << 1;
        if (ok_q[i] && pt >= 37'(d_q[i])) begin
          p_q[i+1] <= pt - 37'(d_q[i]);
          qo_q[i+1] <= {qo_q[i][64:0], 1'b1};
        end else begin
          p_q[i+1] <= pt;
          qo_q[i+1] <= {qo_q[i][64:0], 1'b0};
        end
        d_q[i+1] <= d_q[i];
        ng_q[i+1] <= ng_q[i];
        ok_q[i+1] <= ok_q[i];
        zz_q[i+1] <= zz_q[i];
      end
    end
  end

  logic signed [41:0] zr;
  always_comb begin
    zr = 42'(zz_q[QB]);
    if (ok_q[QB]) zr = ng_q[QB] ? zr - 42'(qo_q[QB]) : zr + 42'(qo_q[QB]);
  end
  always_ff @(posedge clk_i) if (en_i) ang_o <= (zr < 0) ? '0 : 32'(zr);
endmodule

// ----- hdl/geofence_haversine_distance_band.sv -----
// ----------------------------------------------------------------------------
// geofence_haversine_distance_band
// Haversine distance from a fix to a configured target, with proximity band.
//
//   channel | dir | payload
//   s_axis  | in  | tdata: fix_latitude[29:0], fix_longitude[60:30]; tuser fix_valid
//   m_axis  | out | tdata: distance_cm[30:0]; tuser: status[1:0], band[4:2]
//   apb     | in  | 4 registers at 4*i
//
// One fix per cycle while m_axis is not stalled; the sincos, two square
// root, vectoring CORDIC and divider stages make up the pipeline.
// Reset clears the valid bits, target and enable and sets the default radius.
// A stall on m_axis freezes the entire pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module geofence_haversine_distance_band (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // fix_latitude, fix_longitude
  input  logic        s_axis_tuser,  // fix_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // distance_cm
  output logic [4:0]  m_axis_tuser,  // status, band
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ghdb_pkg::*;

  logic signed [29:0] tlat_q;
  logic signed [30:0] tlon_q;
  logic [22:0] rad_q;
  logic en_q;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlat_q <= '0;
      tlon_q <= '0;
      rad_q <= RadiusReset;
      en_q <= 1'b0;
    end else if (wr) begin
      unique case (paddr[3:2])
        RegLat: if ($signed(pwdata[29:0]) >= -LatLimit && $signed(pwdata[29:0]) <= LatLimit)
                  tlat_q <= pwdata[29:0];
        RegLon: if ($signed(pwdata[30:0]) >= -LonLimit && $signed(pwdata[30:0]) <= LonLimit)
                  tlon_q <= pwdata[30:0];
        RegRad: if (pwdata[22:0] >= RadiusMin && pwdata[22:0] <= RadiusMax)
                  rad_q <= pwdata[22:0];
        RegEn:  en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegLat:  prdata = 32'(unsigned'(tlat_q)) & 32'h3fff_ffff;
      RegLon:  prdata = 32'(unsigned'(tlon_q)) & 32'h7fff_ffff;
      RegRad:  prdata = 32'(rad_q);
      RegEn:   prdata = 32'(en_q);
      default: prdata = '0;
    endcase
  end

  // pipeline advances when output slot is free or taken
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  localparam int unsigned LatSc = NumIter + 4;
  localparam int unsigned LatH = 4;
  localparam int unsigned LatAs = 31 + NumIter + DivSteps + 1;
  localparam int unsigned LatAll = LatSc + LatH + 31 + 1 + LatAs + 3;

  logic signed [29:0] flat;
  logic signed [30:0] flon;
  assign flat = s_axis_tdata[29:0];
  assign flon = s_axis_tdata[60:30];

  logic signed [33:0] s1, c1, s2, c2, sf, cf, st, ct;
  ghdb_sincos u_sc1 (.clk_i, .en_i(en), .ang_i(34'(flat) - 34'(tlat_q)), .sin_o(s1), .cos_o(c1));
  ghdb_sincos u_sc2 (.clk_i, .en_i(en), .ang_i(34'(flon) - 34'(tlon_q)), .sin_o(s2), .cos_o(c2));
  ghdb_sincos u_sc3 (.clk_i, .en_i(en), .ang_i(34'(flat) <<< 1), .sin_o(sf), .cos_o(cf));
  ghdb_sincos u_sc4 (.clk_i, .en_i(en), .ang_i(34'(tlat_q) <<< 1), .sin_o(st), .cos_o(ct));

  // h stages
  logic signed [67:0] b_q, s11_q;
  logic signed [33:0] s2a_q, s2b_q;
  logic signed [67:0] s2bb_q, s11b_q;
  logic signed [33:0] s2c_q;
  logic signed [67:0] t_q, s11c_q;
  logic [60:0] h_q;
  logic signed [69:0] hs;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q <= 68'(cf) * 68'(ct);
      s11_q <= 68'(s1) * 68'(s1);
      s2a_q <= s2;
      s2bb_q <= 68'(s2a_q) * 68'(34'(b_q >>> 30));
      s11b_q <= s11_q;
      s2b_q <= s2a_q;
      t_q <= 68'(s2b_q) * 68'(34'(s2bb_q >>> 30));
      s11c_q <= s11b_q;
      s2c_q <= s2b_q;
      h_q <= (hs < 0) ? '0 : ((hs > (70'sd1 <<< 60)) ? (61'd1 << 60) : 61'(hs));
    end
  end
  assign hs = 70'(s11c_q) + 70'(t_q);

  logic [30:0] qs;
  ghdb_isqrt u_hs (.clk_i, .en_i(en), .v_i(h_q[61-1] ? 62'(61'd1 << 60) : 62'(h_q)), .r_o(qs));
  logic signed [33:0] q_q;
  always_ff @(posedge clk_i) if (en) q_q <= 34'(qs);

  logic [31:0] ang;
  ghdb_asin u_as (.clk_i, .en_i(en), .q_i(q_q), .ang_o(ang));

  // side channel: status and radius delayed to match
  side_t sd_q [LatAll+1];
  logic vl_q [LatAll+1];
  always_comb begin
    sd_q[0].status = !s_axis_tuser ? StatusNoFix : (!en_q ? StatusNoTarget : StatusValid);
    sd_q[0].radius = rad_q;
    vl_q[0] = s_axis_tvalid;
  end
  for (genvar i = 0; i < LatAll; i++) begin : g_sd
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vl_q[i+1] <= 1'b0;
      else if (en) vl_q[i+1] <= vl_q[i];
    end
    always_ff @(posedge clk_i) if (en) sd_q[i+1] <= sd_q[i];
  end

  localparam int unsigned AIdx = LatAll - 3;
  logic [63:0] pr_q;
  logic [30:0] dd;
  logic [63:0] dr;
  always_ff @(posedge clk_i) if (en) pr_q <= 64'(sd_q[AIdx].radius) * 64'd200 * 64'(ang);
  assign dr = (pr_q + (64'd1 << 29)) >> 30;
  logic [30:0] d_q;
  always_ff @(posedge clk_i) if (en) d_q <= (dr > 64'(DistMax)) ? DistMax : 31'(dr);
  always_comb dd = d_q;

  logic [2:0] bd;
  always_comb begin
    if (dd <= 31'd2000) bd = 3'd0;
    else if (dd <= 31'd5000) bd = 3'd1;
    else if (dd <= 31'd10000) bd = 3'd2;
    else if (dd <= 31'd25000) bd = 3'd3;
    else if (dd <= 31'd50000) bd = 3'd4;
    else bd = BandFar;
  end

  logic [1:0] stf;
  assign stf = sd_q[LatAll-1].status;
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= (stf == StatusValid) ? {1'b0, dd} : '0;
      m_axis_tuser <= {(stf == StatusValid) ? bd : BandFar, stf};
    end
  end
  assign m_axis_tvalid = vl_q[LatAll];
endmodule
